>>> src/csb_pkg.sv
package csb_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int OP_W        = 3;
    localparam int STAT_W      = 2;
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 7;

    // opcodes
    localparam logic [OP_W-1:0] OP_START   = 3'd0;
    localparam logic [OP_W-1:0] OP_END     = 3'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd3;
    localparam logic [OP_W-1:0] OP_ATTACH  = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd5;
    localparam logic [OP_W-1:0] OP_READ    = 3'd6;

    // result status
    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_CUR = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DATA_W-1:0] entry_value;
    } t_in_beat;

    typedef struct packed {
        logic [STAT_W-1:0]      status;
        logic                   has_item;
        logic [DATA_W-1:0]      current_value;
        logic [COUNT_OUT_W-1:0] item_count;
    } t_out_beat;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic shift_step;
        logic write_val;
        logic read_cur;
        logic capture;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic shift_done;
        logic need_write;
        logic out_free;
    } t_dp_stat;

endpackage

>>> src/csb_ctrl.sv
module csb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  csb_pkg::t_dp_stat i_stat,
    output csb_pkg::t_dp_cmd  o_cmd
);
    import csb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_WRITE = 5'b00100,
        S_READ  = 5'b01000,
        S_CAPT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_done) begin
                    n_state = i_stat.need_write ? S_WRITE : S_READ;
                end
            end
            S_WRITE: begin
                o_cmd.write_val = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                o_cmd.read_cur = 1'b1;
                n_state        = S_CAPT;
            end
            S_CAPT: begin
                // hold until the output register can take the beat
                if (i_stat.out_free) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/csb_datapath.sv
module csb_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csb_pkg::t_dp_cmd   i_cmd,
    output csb_pkg::t_dp_stat  o_stat,
    input  csb_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output csb_pkg::t_out_beat o_out_data
);
    import csb_pkg::*;

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_cursor, n_cursor;
    logic [CNT_W-1:0]       r_mv_left, n_mv_left;
    logic [IDX_W-1:0]       r_src, n_src;
    logic                   r_up, n_up;
    logic [CNT_W-1:0]       r_pos, n_pos;
    logic [STAT_W-1:0]      r_status, n_status;
    logic                   r_need_write, n_need_write;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_wr_pend;
    logic [IDX_W-1:0]       r_wr_addr;
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic                   r_out_valid;
    t_out_beat              r_out;

    logic                   has_cur;
    logic                   full;
    logic                   shift_issue;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;

    // cursor never exceeds count, so inequality means a current item
    assign has_cur = (r_cursor != r_count);
    assign full    = (r_count == CNT_W'(CAPACITY));

    // decode of the accepted beat
    always_comb begin
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_mv_left    = '0;
        n_src        = '0;
        n_up         = 1'b0;
        n_pos        = r_pos;
        n_status     = ST_DONE;
        n_need_write = 1'b0;
        unique case (i_in_data.opcode) inside
            OP_START: n_cursor = '0;
            OP_END:   n_cursor = (r_count != '0) ? r_count - 1'b1 : '0;
            OP_ADVANCE: begin
                if (!has_cur) n_status = ST_NO_CUR;
                else          n_cursor = r_cursor + 1'b1;
            end
            OP_INSERT, OP_ATTACH: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    if (i_in_data.opcode == OP_INSERT) begin
                        n_pos = has_cur ? r_cursor : '0;
                    end else begin
                        n_pos = has_cur ? r_cursor + 1'b1 : r_count;
                    end
                    n_mv_left    = r_count - n_pos;
                    n_src        = IDX_W'(r_count - 1'b1);
                    n_up         = 1'b1;
                    n_need_write = 1'b1;
                    n_count      = r_count + 1'b1;
                    n_cursor     = n_pos;
                end
            end
            OP_REMOVE: begin
                if (!has_cur) begin
                    n_status = ST_NO_CUR;
                end else begin
                    n_mv_left = r_count - r_cursor - 1'b1;
                    n_src     = IDX_W'(r_cursor + 1'b1);
                    n_count   = r_count - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // shift engine: read one slot per cycle, write it one slot over next cycle
    assign shift_issue = i_cmd.shift_step && (r_mv_left != '0);
    assign rd_en       = shift_issue || i_cmd.read_cur;
    assign rd_addr     = shift_issue ? r_src : IDX_W'(r_cursor);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr_addr;
        wr_data = r_rd_data;
        if (r_wr_pend) begin
            wr_en = 1'b1;
        end else if (i_cmd.write_val) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(r_pos);
            wr_data = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_cursor     <= '0;
            r_mv_left    <= '0;
            r_wr_pend    <= 1'b0;
            r_need_write <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count      <= n_count;
                r_cursor     <= n_cursor;
                r_mv_left    <= n_mv_left;
                r_need_write <= n_need_write;
            end else if (shift_issue) begin
                r_mv_left <= r_mv_left - 1'b1;
            end
            r_wr_pend <= shift_issue;
            if (i_cmd.capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src    <= n_src;
            r_up     <= n_up;
            r_pos    <= n_pos;
            r_status <= n_status;
            r_val    <= i_in_data.entry_value[VALUE_WIDTH-1:0];
        end else if (shift_issue) begin
            r_src <= r_up ? r_src - 1'b1 : r_src + 1'b1;
        end
        if (shift_issue) begin
            r_wr_addr <= r_up ? r_src + 1'b1 : r_src - 1'b1;
        end
        if (i_cmd.capture) begin
            r_out.status        <= r_status;
            r_out.has_item      <= has_cur;
            r_out.current_value <= has_cur ? DATA_W'(r_rd_data) : '0;
            r_out.item_count    <= COUNT_OUT_W'(r_count);
        end
    end

    assign o_stat.shift_done = (r_mv_left == '0);
    assign o_stat.need_write = r_need_write;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> src/cursor_sequence_buffer.sv
// Channel | Direction | Handshake               | Beat
// --------+-----------+-------------------------+---------------------------------
// in      | input     | i_in_valid / o_in_ready | t_in_beat  {opcode, entry_value}
// out     | output    | o_out_valid/ i_out_ready| t_out_beat {status, has_item,
//         |           |                         |   current_value, item_count}
//
// Flow: one beat at a time; after accept come the shift, a value write (insert
// and attach only), the cursor read and the capture. Insert, attach and remove
// move up to CAPACITY - 1 stored values, one per cycle: the shift engine reads
// a slot while writing the value it read before into that value's neighbor slot.
// Reset: synchronous, active low; the store is empty and the cursor at none.
// Stalls: the result sits in an output register, so a new beat is taken while
// it waits; the next result waits in the capture step until that register frees.
module cursor_sequence_buffer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  csb_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output csb_pkg::t_out_beat o_out_data
);
    import csb_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing: accept, shift, optional value write, cursor read, capture
    csb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // value memory, count, cursor, shift engine and output register
    csb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sim/cursor_sequence_buffer_test.sv
module cursor_sequence_buffer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csb_pkg::*;

    // The 3-bit opcode field has one code with no operation behind it;
    // the block treats it as a plain read.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Worst case from accept to result: a full shift plus the fixed overhead.
    localparam int DRAIN_CYCLES = CAPACITY + 10;

    // ------------------------------------------------------------------
    // Clock, reset and the DUT
    // ------------------------------------------------------------------
    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    t_in_beat  in_beat  = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_beat;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    cursor_sequence_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the sequence: values, count and cursor.
    // A cursor equal to the count means "no current item".
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] seq_vals [CAPACITY];
    int                seq_count  = 0;
    int                seq_cursor = 0;

    t_in_beat  pending_beats [$];   // stimulus not yet offered to the DUT
    t_out_beat expected_results [$];// predicted results, oldest first

    int errors        = 0;
    int results_seen  = 0;
    int full_hits     = 0;
    int no_cur_hits   = 0;
    int peak_count    = 0;
    bit beat_taken    = 1'b0;       // input beat accepted at the last rising edge

    // Apply one operation to the shadow sequence and return what the DUT
    // should report afterwards.
    function automatic t_out_beat apply_seq_op(t_in_beat b);
        t_out_beat r;
        int        pos;
        bit        cur_valid;
        r         = '0;
        r.status  = ST_DONE;
        cur_valid = seq_cursor < seq_count;
        case (b.opcode) inside
            OP_START: seq_cursor = 0;
            OP_END:   seq_cursor = (seq_count > 0) ? seq_count - 1 : 0;
            OP_ADVANCE: begin
                if (!cur_valid) r.status = ST_NO_CUR;
                else            seq_cursor++;
            end
            OP_INSERT, OP_ATTACH: begin
                if (seq_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // insert goes before current (front if none),
                    // attach goes after current (end if none)
                    if (b.opcode == OP_INSERT) pos = cur_valid ? seq_cursor : 0;
                    else                       pos = cur_valid ? seq_cursor + 1 : seq_count;
                    for (int i = seq_count; i > pos; i--) seq_vals[i] = seq_vals[i-1];
                    seq_vals[pos] = b.entry_value[VALUE_WIDTH-1:0];
                    seq_count++;
                    seq_cursor = pos;
                end
            end
            OP_REMOVE: begin
                if (!cur_valid) begin
                    r.status = ST_NO_CUR;
                end else begin
                    // successor slides into the cursor slot
                    for (int i = seq_cursor; i + 1 < seq_count; i++) seq_vals[i] = seq_vals[i+1];
                    seq_count--;
                end
            end
            default: ;  // read and the unused code change nothing
        endcase
        r.has_item      = seq_cursor < seq_count;
        r.current_value = r.has_item ? DATA_W'(seq_vals[seq_cursor]) : '0;
        r.item_count    = COUNT_OUT_W'(seq_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return DATA_W'($urandom);
    endfunction

    function automatic void queue_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
        t_in_beat b;
        b.opcode      = op;
        b.entry_value = val;
        pending_beats.push_back(b);
    endfunction

    // A run of n random operations. Percentages steer the mix so the store
    // swings between full and empty; the rest are cursor moves and reads.
    function automatic void queue_random_ops(int n, int ins_pct, int rem_pct, int start_pct);
        int              r;
        logic [OP_W-1:0] moves [5];
        moves = '{OP_START, OP_END, OP_ADVANCE, OP_READ, OP_UNUSED};
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                queue_op($urandom_range(0, 1) ? OP_INSERT : OP_ATTACH, pick_value());
            else if (r < ins_pct + rem_pct)
                queue_op(OP_REMOVE, pick_value());
            else if (r < ins_pct + rem_pct + start_pct)
                queue_op(OP_START, pick_value());
            else
                queue_op(moves[$urandom_range(0, 4)], pick_value());
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: bursts of random length separated by random gaps.
    // Changes land on the falling edge; a held beat is never touched.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin : drive_in
        t_in_beat next_beat;
        logic     next_valid;
        next_beat  = in_beat;
        next_valid = in_valid;
        if (i_rst_n && (!in_valid || beat_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_beats.size() > 0) begin
                next_beat  = pending_beats.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    // about a third of the bursts run straight into the next
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        in_beat  <= next_beat;
        in_valid <= next_valid;
    end

    // ------------------------------------------------------------------
    // Output ready: a pattern that switches mode every so often, plus two
    // long hold-offs so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    int mode_left  = 0;
    int ready_mode = 0;
    int hold_left  = 0;
    int holds_done = 0;

    always @(negedge i_clk) begin : drive_ready
        logic next_ready;
        next_ready = 1'b0;
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
            end else if ((holds_done == 0 && results_seen >= 400) ||
                         (holds_done == 1 && results_seen >= 1300)) begin
                hold_left = $urandom_range(300, 500);
                holds_done++;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (ready_mode)
                    0: next_ready = 1'b1;                           // wide open
                    1: next_ready = ($urandom_range(0, 1) == 1);    // coin flip
                    2: next_ready = ($urandom_range(0, 4) == 0);    // mostly stalled
                    default: next_ready = mode_left[0];             // alternating
                endcase
            end
        end
        out_ready <= next_ready;
    end

    // ------------------------------------------------------------------
    // Accept side: predict on every accepted input beat.
    // Check side: compare every accepted output beat with the oldest
    // prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : track_in
        t_out_beat pred;
        beat_taken = i_rst_n && in_valid && in_ready;
        if (beat_taken) begin
            pred = apply_seq_op(in_beat);
            expected_results.push_back(pred);
            if (pred.status == ST_FULL)   full_hits++;
            if (pred.status == ST_NO_CUR) no_cur_hits++;
            if (seq_count > peak_count)   peak_count = seq_count;
        end
    end

    always @(posedge i_clk) begin : check_out
        t_out_beat want;
        if (i_rst_n && out_valid && out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %p",
                         $time, out_beat);
            end else begin
                want = expected_results.pop_front();
                if (out_beat.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, out_beat.status);
                end
                if (out_beat.has_item !== want.has_item) begin
                    errors++;
                    $display("%0t: has_item mismatch, expected %0d, actual %0d",
                             $time, want.has_item, out_beat.has_item);
                end
                if (out_beat.current_value !== want.current_value) begin
                    errors++;
                    $display("%0t: current_value mismatch, expected %h, actual %h",
                             $time, want.current_value, out_beat.current_value);
                end
                if (out_beat.item_count !== want.item_count) begin
                    errors++;
                    $display("%0t: item_count mismatch, expected %0d, actual %0d",
                             $time, want.item_count, out_beat.item_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // Directed: empty-store corner cases first.
        queue_op(OP_READ,    '1);
        queue_op(OP_START,   '0);
        queue_op(OP_END,     '0);
        queue_op(OP_ADVANCE, '0);   // no current item
        queue_op(OP_REMOVE,  '0);   // no current item
        queue_op(OP_ATTACH,  32'h0000_0000);  // attach with no current: append
        queue_op(OP_INSERT,  32'hFFFF_FFFF);  // before current
        queue_op(OP_ADVANCE, '0);
        queue_op(OP_ADVANCE, '0);   // walks off the end: cursor to none
        queue_op(OP_INSERT,  32'h8000_0001);  // no current: goes to the front
        queue_op(OP_END,     '0);
        queue_op(OP_ATTACH,  32'h7FFF_FFFE);  // after the last
        queue_op(OP_START,   '0);
        queue_op(OP_ATTACH,  32'hA5A5_5A5A);  // after the first, mid-sequence
        queue_op(OP_UNUSED,  32'h1234_5678);  // behaves as a read
        queue_op(OP_REMOVE,  '0);   // successor becomes current
        queue_op(OP_END,     '0);
        queue_op(OP_REMOVE,  '0);   // removes the last: cursor to none
        queue_op(OP_REMOVE,  '0);
        queue_op(OP_START,   '0);
        queue_op(OP_REMOVE,  '0);   // removing the head keeps a current item
        queue_op(OP_REMOVE,  '0);
        queue_op(OP_REMOVE,  '0);   // store empty again
        queue_op(OP_READ,    '0);

        // Random: fill to full, churn, drain to empty, churn, four rounds.
        repeat (4) begin
            queue_random_ops(130, 90, 5, 2);
            queue_random_ops(150, 40, 30, 8);
            queue_random_ops(130, 5, 75, 15);
            queue_random_ops(60, 45, 35, 5);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d full-store rejects, %0d no-current rejects,",
                 results_seen, full_hits, no_cur_hits);
        $display("peak occupancy %0d of %0d, two long output hold-offs.",
                 peak_count, CAPACITY);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
